/* sv/name_hash_collision_pair_search_core_macros.svh */
// assertion macros for the pair search core
`ifndef NAME_HASH_COLLISION_PAIR_SEARCH_CORE_MACROS_SVH
`define NAME_HASH_COLLISION_PAIR_SEARCH_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define NHCPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define NHCPS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define NHCPS_ASSERT_IMP(label, clk, rst, ante, cons)
`define NHCPS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/nhcps_pkg.sv */
// shared types, constants and functions of the pair search core
`timescale 1ns / 1ps
package nhcps_pkg;
   localparam int ENTRIES    = 4096;
   localparam int NAME_BYTES = 6;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SUM_W      = CNT_W + 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_FETCH = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEARED = 3'd0,
      ST_LOADED  = 3'd1,
      ST_PAIR    = 3'd2,
      ST_NO_MORE = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [1:0] {CMD_CLEAR, CMD_LOAD, CMD_FETCH, CMD_NONE} cmd_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [47:0] name_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] first_name;
      logic [47:0] second_name;
      logic [31:0] pair_hash;
   } rsp_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [47:0] name;
   } cmd_entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_HASH, S_SORT_INIT, S_RUN_SET, S_M_RD, S_M_HRD, S_M_CMP,
      S_F_TOP, S_F_PH, S_F_KEY, S_B_LOOP, S_B_H, S_B_CMP,
      S_F_MCHK, S_F_MH, S_F_MCMP, S_RESP
   } engine_state_type;

   // 11 to the power of the name length, mod 2^32
   function automatic logic [31:0] partner_mul_calc();
      logic [31:0] t;
      t = 32'd1;
      for (int k = 0; k < NAME_BYTES; k++) t = t * 32'd11;
      return t;
   endfunction

   localparam logic [31:0] PARTNER_MUL = partner_mul_calc();

   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
      logic [31:0] s;
      s = h + {20'd0, c, 4'd0} + {28'd0, c[7:4]};
      return s * 32'd11;
   endfunction

   function automatic logic [7:0] name_byte(input logic [47:0] name, input logic [2:0] k);
      logic [47:0] sh;
      sh = name >> (6'd40 - {k, 3'b000});
      return sh[7:0];
   endfunction
endpackage

/* sv/nhcps_cmd_fifo.sv */
// front end: classifies incoming transactions and queues them for the engine
`timescale 1ns / 1ps
module nhcps_cmd_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  nhcps_pkg::req_type        req,
   output logic                      cmd_valid,
   output nhcps_pkg::cmd_entry_type  cmd,
   input  logic                      cmd_pop
);
   import nhcps_pkg::*;

   cmd_entry_type          mem_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [FPTR_W:0]        count_ff, count_in;
   cmd_entry_type          entry;
   logic                   do_push, do_pop;

   always_comb begin
      entry.name = req.name_bytes;
      unique case (req.opcode)
         OP_CLEAR: entry.cmd = CMD_CLEAR;
         OP_LOAD:  entry.cmd = CMD_LOAD;
         OP_FETCH: entry.cmd = CMD_FETCH;
         default:  entry.cmd = CMD_NONE;
      endcase
   end

   assign full      = (count_ff == (FPTR_W+1)'(FIFO_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= entry;
   end
endmodule

/* sv/nhcps_engine.sv */
// back end: name store, merge sort of the order table and pair search
`timescale 1ns / 1ps
`include "name_hash_collision_pair_search_core_macros.svh"
module nhcps_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  nhcps_pkg::cmd_entry_type  cmd,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output nhcps_pkg::rsp_type        rsp_data
);
   import nhcps_pkg::*;

   logic [47:0]      name_mem [ENTRIES];
   logic [31:0]      hash_mem [ENTRIES];
   logic [IDX_W-1:0] ord0_mem [ENTRIES];
   logic [IDX_W-1:0] ord1_mem [ENTRIES];

   engine_state_type state_ff, state_in;
   cmd_entry_type    cur_ff, cur_in;
   rsp_type          res_ff, res_in;
   logic [CNT_W-1:0] count_ff, count_in, probe_ff, probe_in, match_ff, match_in;
   logic [CNT_W-1:0] i_ff, i_in, w_ff, w_in, a_ff, a_in, b_ff, b_in, o_ff, o_in;
   logic [CNT_W-1:0] mid_ff, mid_in, end_ff, end_in, lo_ff, lo_in, hi_ff, hi_in;
   logic             sorted_ff, sorted_in, aim_ff, aim_in, sel_ff, sel_in;
   logic [2:0]       k_ff, k_in;
   logic [31:0]      h_ff, h_in, key_ff, key_in, phash_ff, phash_in;
   logic [47:0]      pname_ff, pname_in;
   logic [IDX_W-1:0] oa_ff, oa_in, ob_ff, ob_in;

   logic [IDX_W-1:0] ord_ra_addr, ord_rb_addr, hash_ra_addr, hash_rb_addr, name_raddr;
   logic [IDX_W-1:0] ord0_a_q, ord0_b_q, ord1_a_q, ord1_b_q, ord_a, ord_b;
   logic [31:0]      hash_a_q, hash_b_q;
   logic [47:0]      name_q;
   logic             ord_we, ord_wbank, store_we;
   logic [IDX_W-1:0] ord_waddr, ord_wdata;
   logic [31:0]      h_next;
   logic [SUM_W-1:0] sum1, sum2, nxt, two_w;
   logic [CNT_W-1:0] mid_c, bmid;
   logic             take_b;

   assign ord_a = sel_ff ? ord1_a_q : ord0_a_q;
   assign ord_b = sel_ff ? ord1_b_q : ord0_b_q;
   assign h_next = hash_step(h_ff, name_byte(cur_ff.name, k_ff));

   always_ff @(posedge clock) begin
      if (ord_we && !ord_wbank) ord0_mem[ord_waddr] <= ord_wdata;
      if (ord_we && ord_wbank) ord1_mem[ord_waddr] <= ord_wdata;
      if (store_we) begin
         name_mem[count_ff[IDX_W-1:0]] <= cur_ff.name;
         hash_mem[count_ff[IDX_W-1:0]] <= h_next;
      end
      ord0_a_q <= ord0_mem[ord_ra_addr];
      ord0_b_q <= ord0_mem[ord_rb_addr];
      ord1_a_q <= ord1_mem[ord_ra_addr];
      ord1_b_q <= ord1_mem[ord_rb_addr];
      hash_a_q <= hash_mem[hash_ra_addr];
      hash_b_q <= hash_mem[hash_rb_addr];
      name_q   <= name_mem[name_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         sorted_ff <= 1'b0;
         probe_ff  <= '0;
         match_ff  <= '0;
         aim_ff    <= 1'b0;
         sel_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sorted_ff <= sorted_in;
         probe_ff  <= probe_in;
         match_ff  <= match_in;
         aim_ff    <= aim_in;
         sel_ff    <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      res_ff   <= res_in;
      i_ff     <= i_in;
      w_ff     <= w_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      o_ff     <= o_in;
      mid_ff   <= mid_in;
      end_ff   <= end_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      k_ff     <= k_in;
      h_ff     <= h_in;
      key_ff   <= key_in;
      phash_ff <= phash_in;
      pname_ff <= pname_in;
      oa_ff    <= oa_in;
      ob_ff    <= ob_in;
   end

   always_comb begin
      state_in = state_ff;  cur_in = cur_ff;      res_in = res_ff;
      count_in = count_ff;  sorted_in = sorted_ff; probe_in = probe_ff;
      match_in = match_ff;  aim_in = aim_ff;      sel_in = sel_ff;
      i_in = i_ff;  w_in = w_ff;  a_in = a_ff;  b_in = b_ff;  o_in = o_ff;
      mid_in = mid_ff;  end_in = end_ff;  lo_in = lo_ff;  hi_in = hi_ff;
      k_in = k_ff;  h_in = h_ff;  key_in = key_ff;  phash_in = phash_ff;
      pname_in = pname_ff;  oa_in = oa_ff;  ob_in = ob_ff;
      ord_ra_addr = '0;  ord_rb_addr = '0;  hash_ra_addr = '0;  hash_rb_addr = '0;
      name_raddr = '0;  ord_we = 1'b0;  ord_wbank = 1'b0;  ord_waddr = '0;
      ord_wdata = '0;  store_we = 1'b0;  cmd_pop = 1'b0;  rsp_valid = 1'b0;
      sum1 = SUM_W'(i_ff) + SUM_W'(w_ff);
      mid_c = (sum1 < SUM_W'(count_ff)) ? CNT_W'(sum1) : count_ff;
      sum2 = SUM_W'(mid_c) + SUM_W'(w_ff);
      two_w = {w_ff, 1'b0};
      nxt = SUM_W'(i_ff) + two_w;
      bmid = lo_ff + ((hi_ff - lo_ff) >> 1);
      take_b = (a_ff >= mid_ff) || ((b_ff < end_ff) && (hash_b_q < hash_a_q));

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in = cmd;
               res_in = '0;
               unique case (cmd.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;  sorted_in = 1'b0;
                     probe_in = '0;  match_in = '0;
                     res_in.status = ST_CLEARED;
                     state_in = S_RESP;
                  end
                  CMD_LOAD: begin
                     if (count_ff == CNT_W'(ENTRIES)) begin
                        res_in.status = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        h_in = '0;  k_in = '0;
                        state_in = S_HASH;
                     end
                  end
                  CMD_FETCH: begin
                     if (!sorted_ff) begin
                        sel_in = 1'b0;  i_in = '0;
                        state_in = S_SORT_INIT;
                     end else begin
                        state_in = S_F_TOP;
                     end
                  end
                  default: begin
                     res_in.status = ST_NO_MORE;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_HASH: begin
            h_in = h_next;
            k_in = k_ff + 1'b1;
            if (k_ff == 3'(NAME_BYTES - 1)) begin
               store_we = 1'b1;
               count_in = count_ff + 1'b1;
               sorted_in = 1'b0;
               res_in.status = ST_LOADED;
               state_in = S_RESP;
            end
         end
         S_SORT_INIT: begin
            if (i_ff < count_ff) begin
               ord_we = 1'b1;
               ord_waddr = i_ff[IDX_W-1:0];
               ord_wdata = i_ff[IDX_W-1:0];
               i_in = i_ff + 1'b1;
            end else begin
               w_in = CNT_W'(1);
               i_in = '0;
               if (count_ff > CNT_W'(1)) begin
                  state_in = S_RUN_SET;
               end else begin
                  sorted_in = 1'b1;  probe_in = '0;  match_in = '0;  aim_in = 1'b1;
                  state_in = S_F_TOP;
               end
            end
         end
         S_RUN_SET: begin
            mid_in = mid_c;
            end_in = (sum2 < SUM_W'(count_ff)) ? CNT_W'(sum2) : count_ff;
            a_in = i_ff;  b_in = mid_c;  o_in = i_ff;
            state_in = S_M_RD;
         end
         S_M_RD: begin
            ord_ra_addr = a_ff[IDX_W-1:0];
            ord_rb_addr = b_ff[IDX_W-1:0];
            state_in = S_M_HRD;
         end
         S_M_HRD: begin
            hash_ra_addr = ord_a;
            hash_rb_addr = ord_b;
            oa_in = ord_a;  ob_in = ord_b;
            state_in = S_M_CMP;
         end
         S_M_CMP: begin
            ord_we = 1'b1;
            ord_wbank = !sel_ff;
            ord_waddr = o_ff[IDX_W-1:0];
            ord_wdata = take_b ? ob_ff : oa_ff;
            if (take_b) b_in = b_ff + 1'b1;
            else a_in = a_ff + 1'b1;
            o_in = o_ff + 1'b1;
            if (o_ff + 1'b1 == end_ff) begin
               if (nxt >= SUM_W'(count_ff)) begin
                  // pass complete, the written bank becomes the source
                  sel_in = !sel_ff;
                  i_in = '0;
                  if (two_w >= SUM_W'(count_ff)) begin
                     sorted_in = 1'b1;  probe_in = '0;  match_in = '0;  aim_in = 1'b1;
                     state_in = S_F_TOP;
                  end else begin
                     w_in = CNT_W'(two_w);
                     state_in = S_RUN_SET;
                  end
               end else begin
                  i_in = CNT_W'(nxt);
                  state_in = S_RUN_SET;
               end
            end else begin
               state_in = S_M_RD;
            end
         end
         S_F_TOP: begin
            if (probe_ff < count_ff) begin
               ord_ra_addr = probe_ff[IDX_W-1:0];
               state_in = S_F_PH;
            end else begin
               res_in = '0;
               res_in.status = ST_NO_MORE;
               state_in = S_RESP;
            end
         end
         S_F_PH: begin
            hash_ra_addr = ord_a;
            name_raddr = ord_a;
            state_in = S_F_KEY;
         end
         S_F_KEY: begin
            phash_in = hash_a_q;
            pname_in = name_q;
            key_in = (32'd0 - hash_a_q) * PARTNER_MUL;
            if (aim_ff) begin
               lo_in = '0;  hi_in = count_ff;
               state_in = S_B_LOOP;
            end else begin
               state_in = S_F_MCHK;
            end
         end
         S_B_LOOP: begin
            // lower bound search for the partner hash
            if (lo_ff < hi_ff) begin
               mid_in = bmid;
               ord_ra_addr = bmid[IDX_W-1:0];
               state_in = S_B_H;
            end else begin
               match_in = lo_ff;
               aim_in = 1'b0;
               state_in = S_F_MCHK;
            end
         end
         S_B_H: begin
            hash_ra_addr = ord_a;
            state_in = S_B_CMP;
         end
         S_B_CMP: begin
            if (hash_a_q < key_ff) lo_in = mid_ff + 1'b1;
            else hi_in = mid_ff;
            state_in = S_B_LOOP;
         end
         S_F_MCHK: begin
            if (match_ff < count_ff) begin
               ord_ra_addr = match_ff[IDX_W-1:0];
               state_in = S_F_MH;
            end else begin
               probe_in = probe_ff + 1'b1;
               aim_in = 1'b1;
               state_in = S_F_TOP;
            end
         end
         S_F_MH: begin
            hash_ra_addr = ord_a;
            name_raddr = ord_a;
            state_in = S_F_MCMP;
         end
         S_F_MCMP: begin
            if (hash_a_q == key_ff) begin
               res_in.status = ST_PAIR;
               res_in.first_name = pname_ff;
               res_in.second_name = name_q;
               res_in.pair_hash = phash_ff;
               match_in = match_ff + 1'b1;
               state_in = S_RESP;
            end else begin
               probe_in = probe_ff + 1'b1;
               aim_in = 1'b1;
               state_in = S_F_TOP;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_data = res_ff;

   `NHCPS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(ENTRIES))
   `NHCPS_ASSERT_IMP(a_merge_in_run, clock, reset, state_ff == S_M_CMP, o_ff < end_ff)
   `NHCPS_ASSERT_IMP(a_search_open, clock, reset, state_ff == S_B_CMP, lo_ff < hi_ff)
   `NHCPS_ASSERT_NXT(a_resp_done, clock, reset, rsp_valid && rsp_ready, state_ff == S_IDLE)
endmodule

/* sv/name_hash_collision_pair_search_core.sv */
// Pair search core: loads 6-byte names, hashes them, and on fetch returns one
// name pair per transaction whose joined hash is zero. A load hashes the name
// with one hash step per name byte. The first fetch after a load first rebuilds
// the order table by a bottom-up merge sort, each merge step a read of the order
// memory, a read of the hash memory and a compare-and-write. Each fetch then
// skips probes and runs binary-search steps, each step one read of the order
// and hash memories. Transactions queue in a four-deep command queue and one
// result register parts the result side.
`timescale 1ns / 1ps
module name_hash_collision_pair_search_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  nhcps_pkg::req_type  req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output nhcps_pkg::rsp_type  rsp_data
);
   import nhcps_pkg::*;

   cmd_entry_type cmd;
   logic          cmd_valid, cmd_pop, eng_valid, eng_ready;
   rsp_type       eng_data, out_ff;
   logic          out_full_ff;

   nhcps_cmd_fifo u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .req       (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   nhcps_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (eng_valid),
      .rsp_ready (eng_ready),
      .rsp_data  (eng_data)
   );

   assign eng_ready = !out_full_ff || rsp_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (eng_valid && eng_ready) begin
         out_full_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_valid && eng_ready) out_ff <= eng_data;
   end

   assign rsp_empty = !out_full_ff;
   assign rsp_data  = out_ff;
endmodule

/* sim/tb_name_hash_collision_pair_search_core.sv */
// self-checking testbench of the name hash pair search core
`timescale 1ns / 1ps
module tb_name_hash_collision_pair_search_core;
   import nhcps_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000000;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   name_hash_collision_pair_search_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // predictor state
   logic [47:0] stored_names [ENTRIES];
   logic [31:0] stored_hashes[ENTRIES];
   int          hash_order   [ENTRIES];
   int          names_held;
   bit          order_valid;
   int          probe_pos;
   int          match_pos;

   rsp_type pending_rsps[$];
   int      mismatches;
   int      idle_pct;
   int      items_sent;
   int      quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] name_hash_of(input logic [47:0] n);
      logic [31:0] h;
      logic [7:0]  c;
      h = '0;
      for (int k = 0; k < NAME_BYTES; k++) begin
         c = n[47 - 8 * k -: 8];
         h = (h + {20'd0, c, 4'd0} + {28'd0, c[7:4]}) * 32'd11;
      end
      return h;
   endfunction

   function automatic logic [31:0] partner_key(input logic [31:0] h);
      logic [31:0] t;
      t = -h;
      for (int k = 0; k < NAME_BYTES; k++) t = t * 32'd11;
      return t;
   endfunction

   // stable insertion sort on hash
   function automatic void order_by_hash();
      int j;
      int v;
      for (int i = 0; i < names_held; i++) begin
         v = i;
         j = i;
         while (j > 0 && stored_hashes[hash_order[j - 1]] > stored_hashes[v]) begin
            hash_order[j] = hash_order[j - 1];
            j--;
         end
         hash_order[j] = v;
      end
   endfunction

   function automatic int lower_bound(input logic [31:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = names_held;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (stored_hashes[hash_order[mid]] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic void aim_at_partners();
      if (probe_pos < names_held)
         match_pos = lower_bound(partner_key(stored_hashes[hash_order[probe_pos]]));
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type o;
      int      pi;
      o = '0;
      o.status = ST_NO_MORE;
      case (r.opcode)
         OP_CLEAR: begin
            names_held  = 0;
            order_valid = 0;
            probe_pos   = 0;
            match_pos   = 0;
            o.status    = ST_CLEARED;
         end
         OP_LOAD: begin
            if (names_held >= ENTRIES) begin
               o.status = ST_FULL;
            end else begin
               stored_names[names_held]  = r.name_bytes;
               stored_hashes[names_held] = name_hash_of(r.name_bytes);
               names_held++;
               order_valid = 0;
               o.status    = ST_LOADED;
            end
         end
         OP_FETCH: begin
            if (!order_valid) begin
               order_by_hash();
               order_valid = 1;
               probe_pos   = 0;
               match_pos   = 0;
               aim_at_partners();
            end
            while (probe_pos < names_held) begin
               pi = hash_order[probe_pos];
               if (match_pos < names_held &&
                   stored_hashes[hash_order[match_pos]] == partner_key(stored_hashes[pi])) begin
                  o.status      = ST_PAIR;
                  o.first_name  = stored_names[pi];
                  o.second_name = stored_names[hash_order[match_pos]];
                  o.pair_hash   = stored_hashes[pi];
                  match_pos++;
                  return o;
               end
               probe_pos++;
               aim_at_partners();
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [47:0] name);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{opcode: op, name_bytes: name};
      do @(posedge clock); while (req_full);
      pending_rsps.push_back(predict_response('{opcode: op, name_bytes: name}));
      items_sent++;
   endtask

   task automatic wait_drained();
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [47:0] random_name();
      return {16'($urandom_range(16'hffff, 0)), $urandom()};
   endfunction

   // checks each result transaction against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.first_name !== want.first_name) begin
                  $display("%0t: first_name expected %h actual %h",
                           $time, want.first_name, rsp_data.first_name);
                  mismatches++;
               end
               if (rsp_data.second_name !== want.second_name) begin
                  $display("%0t: second_name expected %h actual %h",
                           $time, want.second_name, rsp_data.second_name);
                  mismatches++;
               end
               if (rsp_data.pair_hash !== want.pair_hash) begin
                  $display("%0t: pair_hash expected %h actual %h",
                           $time, want.pair_hash, rsp_data.pair_hash);
                  mismatches++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_basic_ops();
      send_item(OP_CLEAR, '0);
      send_item(OP_FETCH, '0);
      send_item(OP_NONE, 48'hffff_ffff_ffff);
      send_item(OP_LOAD, 48'hffff_ffff_ffff);
      send_item(OP_LOAD, '0);
      send_item(OP_LOAD, 48'h8000_0000_0001);
      send_item(OP_LOAD, '0);
      send_item(OP_LOAD, '0);
      repeat (11) send_item(OP_FETCH, '0);
      // hold the sender until every result is back
      req_push <= 1'b0;
      wait_drained();
      // load after a fetch restarts the walk
      send_item(OP_LOAD, '0);
      repeat (18) send_item(OP_FETCH, 48'hffff_ffff_ffff);
   endtask

   // names that differ by one in a byte and eleven in the next share a hash
   task automatic test_equal_hashes();
      logic [47:0] n;
      send_item(OP_CLEAR, '0);
      repeat (4) begin
         n = random_name();
         n[11:8] = 4'h5;
         n[3:0]  = 4'h2;
         send_item(OP_LOAD, n);
         send_item(OP_LOAD, n - 48'h100 + 48'd11);
         send_item(OP_LOAD, '0);
      end
      repeat (22) send_item(OP_FETCH, '0);
   endtask

   task automatic test_store_full();
      idle_pct = 0;
      send_item(OP_CLEAR, '0);
      send_item(OP_LOAD, '0);
      send_item(OP_LOAD, '0);
      for (int i = 2; i < ENTRIES; i++) send_item(OP_LOAD, random_name());
      send_item(OP_LOAD, random_name());
      send_item(OP_FETCH, '0);
      send_item(OP_CLEAR, '0);
      idle_pct = 15;
   endtask

   task automatic test_random_sessions();
      int start_count;
      int loads;
      start_count = items_sent;
      while (items_sent - start_count < 1350) begin
         // a stretch of back-to-back traffic on both sides
         idle_pct = (items_sent - start_count > 400 &&
                     items_sent - start_count < 600) ? 0 : 15;
         if ($urandom_range(9) < 8) send_item(OP_CLEAR, random_name());
         loads = $urandom_range(10, 1);
         repeat (loads) begin
            case ($urandom_range(9))
               0, 1, 2: send_item(OP_LOAD, '0);
               3:       send_item(OP_LOAD, 48'hffff_ffff_ffff);
               default: send_item(OP_LOAD, random_name());
            endcase
         end
         repeat ($urandom_range(14, 1)) begin
            case ($urandom_range(19))
               0:       send_item(OP_NONE, random_name());
               1:       send_item(OP_LOAD, $urandom_range(1) ? 48'h0 : random_name());
               2:       send_item(2'($urandom_range(3)), random_name());
               default: send_item(OP_FETCH, random_name());
            endcase
         end
         if ($urandom_range(19) == 0) begin
            req_push <= 1'b0;
            wait_drained();
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_push   = 1'b0;
      req_data   = '0;
      rsp_pop    = 1'b0;
      mismatches = 0;
      items_sent = 0;
      idle_pct   = 15;
      quiet_cycles = 0;
      names_held = 0;
      order_valid = 0;
      probe_pos  = 0;
      match_pos  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_equal_hashes();
      test_store_full();
      test_random_sessions();
      req_push <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
